// File: hdl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the spot centroid block
// Field widths, register indexes and the control group of the pixel
// accumulator.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int CFG_W     = 13;   // configuration data width
    localparam int CFG_IDX_W = 2;    // configuration register index width
    localparam int PIX_W     = 8;    // pixel width
    localparam int OUT_W     = 13;   // width of each signed offset

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // Pixel value that counts in exact-match mode
    localparam logic [PIX_W-1:0] PIXEL_FULL = 8'd255;

    // Status codes of a result
    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    // Control group from the sequencer to the accumulator
    typedef struct packed {
        logic step;        // one pixel transfers this cycle
        logic clear;       // restart the frame: indices and totals to zero
        logic match_mode;  // 0: pixel == 255 counts, 1: pixel != 0 counts
    } t_acc_ctl;

endpackage

// File: hdl/scp_accum.sv
// ----------------------------------------------------------------------------
// scp_accum: raster position counters and running totals
// Tracks column and row of the next pixel and sums the column, the row and
// one for every counted pixel of the current frame.
// ----------------------------------------------------------------------------
module scp_accum #(
    parameter int IW = 12,
    parameter int CW = 25,
    parameter int TW = 37
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  scp_pkg::t_acc_ctl           i_ctl,
    input  logic [scp_pkg::PIX_W-1:0]   i_pixel,
    input  logic [IW-1:0]               i_last_col,
    input  logic [IW-1:0]               i_last_row,
    output logic                        o_frame_end,
    output logic [TW-1:0]               o_col_total,
    output logic [TW-1:0]               o_row_total,
    output logic [CW-1:0]               o_hit_count
);

    logic [IW-1:0] r_col;
    logic [IW-1:0] r_row;
    logic [TW-1:0] r_col_total;
    logic [TW-1:0] r_row_total;
    logic [CW-1:0] r_hit_count;
    logic          hit;
    logic          last_col;
    logic          last_row;

    assign hit = i_ctl.match_mode ? (i_pixel != '0) : (i_pixel == scp_pkg::PIXEL_FULL);
    assign last_col = (r_col == i_last_col);
    assign last_row = (r_row == i_last_row);
    assign o_frame_end = i_ctl.step && last_col && last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_col       <= '0;
            r_row       <= '0;
            r_col_total <= '0;
            r_row_total <= '0;
            r_hit_count <= '0;
        end else if (i_ctl.step) begin
            if (hit) begin
                r_col_total <= r_col_total + TW'(r_col);
                r_row_total <= r_row_total + TW'(r_row);
                r_hit_count <= r_hit_count + CW'(1);
            end
            // wrap at end of line, and at end of frame back to the origin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + IW'(1);
            end else begin
                r_col <= r_col + IW'(1);
            end
        end
    end

    assign o_col_total = r_col_total;
    assign o_row_total = r_row_total;
    assign o_hit_count = r_hit_count;

endmodule

// File: hdl/scp_divider.sv
// ----------------------------------------------------------------------------
// scp_divider: shared restoring divider
// One quotient bit per cycle over the whole dividend; the quotient is known
// to fit in IW bits, so only those are kept.
// ----------------------------------------------------------------------------
module scp_divider #(
    parameter int IW = 12,
    parameter int CW = 25,
    parameter int TW = 37
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [TW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [IW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(TW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [TW-1:0]    r_dvd;
    logic [CW-1:0]    r_den;
    logic [CW-1:0]    r_rem;
    logic [IW-1:0]    r_quo;
    logic [CW:0]      trial;
    logic [CW:0]      diff;
    logic             qbit;
    logic             last_step;

    assign trial     = {r_rem, r_dvd[TW-1]};
    assign diff      = trial - {1'b0, r_den};
    assign qbit      = (trial >= {1'b0, r_den});
    assign last_step = (r_cnt == CNT_W'(TW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= qbit ? diff[CW-1:0] : trial[CW-1:0];
            r_quo <= IW'({r_quo, qbit});
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hdl/spot_centroid_offset.sv
// ----------------------------------------------------------------------------
// spot_centroid_offset: centroid offset of the counted pixels of a frame
// Takes a mask frame in raster order and reports where the counted pixels
// lie relative to the frame center.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_pixel) carries one 8-bit pixel per
//   transfer in raster order. The block counts column and row itself from
//   the configured frame size. Pixels stream in at one per cycle while
//   o_ready is high. After the last pixel of a frame the block runs two
//   divisions on one shared restoring divider (one quotient bit per cycle)
//   and drops o_ready meanwhile; the dividend has TW = 3*clog2(MAX_DIM)+1
//   bits (37 at the default MAX_DIM of 4096). An empty frame skips the
//   divider and goes from S_START straight to S_DONE.
//   Output channel (o_valid / i_ready) carries one result per frame:
//   o_status (0 found, 1 nothing counted), o_center_x = mean column minus
//   half width, o_center_y = half height minus mean row, both zero when
//   nothing counted. The result is held in an output register; the block
//   takes pixels of the next frame while it waits, and only stalls at the
//   next frame end if the receiver still has not taken it.
//   Configuration (i_cfg_valid / o_cfg_ready) is always ready. Writing
//   frame_width or frame_height restarts the frame; match_mode only
//   changes the test for later pixels. Write only while idle.
//   Reset: synchronous, active low; size 640 x 480, mode 0, totals cleared.
// ----------------------------------------------------------------------------
module spot_centroid_offset #(
    parameter int MAX_DIM = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [scp_pkg::PIX_W-1:0]         i_pixel,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_status,
    output logic signed [scp_pkg::OUT_W-1:0]  o_center_x,
    output logic signed [scp_pkg::OUT_W-1:0]  o_center_y,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scp_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int IW = $clog2(MAX_DIM);       // row / column index width
    localparam int DW = $clog2(MAX_DIM + 1);   // effective frame size width
    localparam int CW = 2 * IW + 1;            // hit count width
    localparam int TW = CW + IW;               // column / row total width
    localparam int RW = ((IW > scp_pkg::OUT_W) ? IW : scp_pkg::OUT_W) + 1;

    typedef enum logic [4:0] {
        S_ACC   = 5'b00001,   // stream pixels
        S_START = 5'b00010,   // frame done, totals settled
        S_DIVX  = 5'b00100,   // column total / count
        S_DIVY  = 5'b01000,   // row total / count
        S_DONE  = 5'b10000    // load output register
    } t_state;

    // Clamp a written size: zero acts as one, above MAX_DIM as MAX_DIM
    function automatic logic [DW-1:0] eff_dim(input logic [scp_pkg::CFG_W-1:0] v);
        logic [DW-1:0] f;
        if (v == '0) begin
            f = DW'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            f = DW'(MAX_DIM);
        end else begin
            f = DW'(v);
        end
        return f;
    endfunction

    t_state              r_state;
    t_state              n_state;
    logic [IW-1:0]       r_last_col;
    logic [IW-1:0]       r_last_row;
    logic [IW-1:0]       r_half_w;
    logic [IW-1:0]       r_half_h;
    logic                r_mode;
    logic                r_found;
    logic [IW-1:0]       r_mean_c;
    logic [IW-1:0]       r_mean_r;
    logic                r_out_valid;
    logic                r_status;
    logic [scp_pkg::OUT_W-1:0] r_cx;
    logic [scp_pkg::OUT_W-1:0] r_cy;

    logic                cfg_wr;
    logic                size_wr;
    logic [DW-1:0]       cfg_eff;
    logic [DW-1:0]       rst_eff_w;
    logic [DW-1:0]       rst_eff_h;
    scp_pkg::t_acc_ctl   acc_ctl;
    logic                frame_end;
    logic [TW-1:0]       col_total;
    logic [TW-1:0]       row_total;
    logic [CW-1:0]       hit_count;
    logic                div_start;
    logic [TW-1:0]       div_dividend;
    logic                div_done;
    logic [IW-1:0]       div_quotient;
    logic                out_load;
    logic [RW-1:0]       diff_x;
    logic [RW-1:0]       diff_y;

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign size_wr     = cfg_wr && ((i_cfg_index == scp_pkg::CFG_FRAME_WIDTH) ||
                                    (i_cfg_index == scp_pkg::CFG_FRAME_HEIGHT));
    assign cfg_eff     = eff_dim(i_cfg_data);
    assign rst_eff_w   = eff_dim(scp_pkg::WIDTH_RESET);
    assign rst_eff_h   = eff_dim(scp_pkg::HEIGHT_RESET);

    // Keep the derived forms of the sizes: last index and half size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= IW'(rst_eff_w - DW'(1));
            r_half_w   <= IW'(rst_eff_w >> 1);
            r_last_row <= IW'(rst_eff_h - DW'(1));
            r_half_h   <= IW'(rst_eff_h >> 1);
            r_mode     <= 1'b0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                scp_pkg::CFG_FRAME_WIDTH: begin
                    r_last_col <= IW'(cfg_eff - DW'(1));
                    r_half_w   <= IW'(cfg_eff >> 1);
                end
                scp_pkg::CFG_FRAME_HEIGHT: begin
                    r_last_row <= IW'(cfg_eff - DW'(1));
                    r_half_h   <= IW'(cfg_eff >> 1);
                end
                scp_pkg::CFG_MATCH_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // ----------------------------------------------------------- accumulator
    assign o_ready = (r_state == S_ACC);

    assign acc_ctl.step       = i_valid && o_ready;
    // restart on a size write; after the second division is launched the
    // totals of the finished frame are no longer needed
    assign acc_ctl.clear      = size_wr || ((r_state == S_DIVX) && div_done);
    assign acc_ctl.match_mode = r_mode;

    scp_accum #(
        .IW (IW),
        .CW (CW),
        .TW (TW)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (acc_ctl),
        .i_pixel     (i_pixel),
        .i_last_col  (r_last_col),
        .i_last_row  (r_last_row),
        .o_frame_end (frame_end),
        .o_col_total (col_total),
        .o_row_total (row_total),
        .o_hit_count (hit_count)
    );

    // --------------------------------------------------------------- divider
    assign div_start    = ((r_state == S_START) && (hit_count != '0)) ||
                          ((r_state == S_DIVX) && div_done);
    assign div_dividend = (r_state == S_START) ? col_total : row_total;

    scp_divider #(
        .IW (IW),
        .CW (CW),
        .TW (TW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (hit_count),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // ------------------------------------------------------------- sequencer
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACC: begin
                if (frame_end) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = (hit_count != '0) ? S_DIVX : S_DONE;
            end
            S_DIVX: begin
                if (div_done) begin
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the quotients and whether anything counted
    always_ff @(posedge i_clk) begin
        if (r_state == S_START) begin
            r_found <= (hit_count != '0);
        end
        if ((r_state == S_DIVX) && div_done) begin
            r_mean_c <= div_quotient;
        end
        if ((r_state == S_DIVY) && div_done) begin
            r_mean_r <= div_quotient;
        end
    end

    // ------------------------------------------------------- output register
    // Offsets are kept modulo 2^OUT_W, as the result fields are
    assign diff_x = RW'(r_mean_c) - RW'(r_half_w);
    assign diff_y = RW'(r_half_h) - RW'(r_mean_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_status <= r_found ? scp_pkg::STATUS_FOUND : scp_pkg::STATUS_NOT_FOUND;
            r_cx     <= r_found ? diff_x[scp_pkg::OUT_W-1:0] : '0;
            r_cy     <= r_found ? diff_y[scp_pkg::OUT_W-1:0] : '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_center_x = r_cx;
    assign o_center_y = r_cy;

endmodule

// File: hdl/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_checker: port-level checks of the spot centroid block
// Watches the result and configuration channels over time.
// ----------------------------------------------------------------------------
module scp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_ready,
    input  logic                              o_valid,
    input  logic                              i_ready,
    input  logic                              o_status,
    input  logic signed [scp_pkg::OUT_W-1:0]  o_center_x,
    input  logic signed [scp_pkg::OUT_W-1:0]  o_center_y,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) &&
        $stable(o_center_x) && $stable(o_center_y))
        else $error("result changed while stalled");

    // An empty frame reports zero offsets
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == scp_pkg::STATUS_NOT_FOUND) |->
        (o_center_x == '0) && (o_center_y == '0))
        else $error("nonzero offset on empty frame");

    // A found spot lies within half a maximum frame of the center
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == scp_pkg::STATUS_FOUND) |->
        (o_center_x >= -13'sd2048) && (o_center_x <= 13'sd2048) &&
        (o_center_y >= -13'sd2048) && (o_center_y <= 13'sd2048))
        else $error("offset out of range");

    // Configuration is never back-pressured
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

    // A new result is only loaded while the pixel side is halted
    a_load_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared while pixels streamed");

endmodule

bind spot_centroid_offset scp_checker u_scp_checker (.*);
